>>> rtl/fpp_pkg.sv
// fpp_pkg: shared constants, codes and types for the framed packet parser
// depends on nothing; used by fpp_if.sv, fpp_crc16.sv and the top level
`default_nettype none

package fpp_pkg;

  // frame markers and crc constants
  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // frame length covers device, command and sequence bytes plus payload
  localparam logic [15:0] LEN_OVERHEAD = 16'd3;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int PLEN_W    = 9;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 9;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CRC  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEN  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_VALUE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 8'd1;

  // configuration reset values
  localparam logic [7:0]        TAIL_VALUE_RST    = 8'd22;
  localparam logic [PLEN_W-1:0] PAYLOAD_LIMIT_RST = 9'd256;

  // crc unit control from the parser
  typedef struct packed {
    logic init;
    logic feed;
  } crc_ctl_t;

  // one byte of crc16-modbus, reflected, lsb first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fpp_if.sv
// fpp_if: valid/ready channel interfaces for received bytes, results and config
// depends on fpp_pkg
`default_nettype none

// received byte channel
interface fpp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [fpp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// parser result channel
interface fpp_result_if;
  logic                        valid;
  logic                        ready;
  logic [fpp_pkg::KIND_W-1:0]  kind;
  logic [fpp_pkg::BYTE_W-1:0]  data_byte;
  logic [fpp_pkg::BYTE_W-1:0]  byte_index;
  logic [fpp_pkg::BYTE_W-1:0]  command;
  logic [fpp_pkg::PLEN_W-1:0]  payload_len;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output command, output payload_len, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input command, input payload_len, output ready);
endinterface

// configuration write channel
interface fpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpp_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [fpp_pkg::CFG_DAT_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/framed_packet_parser_crc16_core.sv
// framed_packet_parser_crc16_core: byte-stream frame parser with crc16-modbus check
// depends on fpp_pkg, fpp_if.sv (channel interfaces) and fpp_crc16
//
//   channel  role  payload                                          notes
//   rx       sink  rx_byte                                          one byte per transaction
//   res      src   kind, data_byte, byte_index, command, payload_len  zero or one per byte
//   cfg      sink  reg_index, wdata                                 always ready
//
// for every byte, frame state, counters and the crc byte update
// all settle between the input handshake and the result register.
// a byte is taken whenever the result register is empty or being drained,
// so a new byte can enter every cycle while res keeps up.
// rst is synchronous: parser back to header hunt, crc to 0xFFFF, config to
// its defaults; a stalled result holds rx off until it is taken.
`default_nettype none

module framed_packet_parser_crc16_core #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  fpp_byte_if.sink           rx,
  fpp_result_if.source       res,
  fpp_cfg_if.sink            cfg
);

  // payload counter only needs to reach the smaller of the limits
  localparam int CAP   = (MAX_PAYLOAD < 511) ? MAX_PAYLOAD : 511;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [15:0] MAX_P16 = 16'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    ST_H0, ST_H1, ST_LENH, ST_LENL, ST_DEV, ST_CMD, ST_SEQ,
    ST_DATA, ST_CRCH, ST_CRCL, ST_TAIL
  } phase_t;

  phase_t                           phase, phase_next;
  logic [7:0]                       len_hi;
  logic [CNT_W-1:0]                 length_left;
  logic [fpp_pkg::PLEN_W-1:0]       frame_len;
  logic [7:0]                       payload_pos;
  logic [7:0]                       cmd_held;
  logic [7:0]                       crc_rx_hi;
  logic [15:0]                      crc_received;
  logic [15:0]                      crc_running;
  logic [7:0]                       tail_value;
  logic [fpp_pkg::PLEN_W-1:0]       payload_limit;

  logic                             rx_fire;
  logic [7:0]                       b;
  logic [15:0]                      len16;
  logic [15:0]                      plen16;
  logic [15:0]                      limit16;
  logic                             len_bad;
  logic                             emit;
  logic [fpp_pkg::KIND_W-1:0]       emit_kind;
  fpp_pkg::crc_ctl_t                crc_ctl;

  // byte enters when the result register is free this cycle
  assign rx.ready  = !res.valid || res.ready;
  assign rx_fire   = rx.valid && rx.ready;
  assign b         = rx.rx_byte;
  assign cfg.ready = 1'b1;

  // length check on the low length byte
  assign len16   = {len_hi, b};
  assign plen16  = len16 - fpp_pkg::LEN_OVERHEAD;
  assign limit16 = ({7'd0, payload_limit} < MAX_P16) ? {7'd0, payload_limit} : MAX_P16;
  assign len_bad = (len16 < fpp_pkg::LEN_OVERHEAD) || (plen16 > limit16);

  // next phase, result decision and crc control
  always_comb begin
    phase_next   = phase;
    emit         = 1'b0;
    emit_kind    = fpp_pkg::KIND_DATA;
    crc_ctl.init = 1'b0;
    crc_ctl.feed = 1'b0;
    unique case (phase)
      ST_H0: begin
        if (b == fpp_pkg::HDR_FIRST) phase_next = ST_H1;
      end
      ST_H1: begin
        phase_next = (b == fpp_pkg::HDR_SECOND) ? ST_LENH : ST_H0;
      end
      ST_LENH: phase_next = ST_LENL;
      ST_LENL: begin
        if (len_bad) begin
          phase_next = ST_H0;
          emit       = 1'b1;
          emit_kind  = fpp_pkg::KIND_LEN;
        end else begin
          phase_next   = ST_DEV;
          crc_ctl.init = 1'b1;
        end
      end
      ST_DEV: begin
        crc_ctl.feed = 1'b1;
        phase_next   = ST_CMD;
      end
      ST_CMD: begin
        crc_ctl.feed = 1'b1;
        phase_next   = ST_SEQ;
      end
      ST_SEQ: begin
        crc_ctl.feed = 1'b1;
        phase_next   = (length_left != '0) ? ST_DATA : ST_CRCH;
      end
      ST_DATA: begin
        crc_ctl.feed = 1'b1;
        emit         = 1'b1;
        emit_kind    = fpp_pkg::KIND_DATA;
        if (length_left == CNT_W'(1)) phase_next = ST_CRCH;
      end
      ST_CRCH: phase_next = ST_CRCL;
      ST_CRCL: phase_next = ST_TAIL;
      ST_TAIL: begin
        emit       = 1'b1;
        phase_next = ST_H0;
        if (b != tail_value) begin
          emit_kind = fpp_pkg::KIND_TAIL;
        end else if (crc_running != crc_received) begin
          emit_kind = fpp_pkg::KIND_CRC;
        end else begin
          emit_kind = fpp_pkg::KIND_GOOD;
        end
      end
      default: phase_next = ST_H0;
    endcase
    if (!rx_fire) begin
      phase_next   = phase;
      emit         = 1'b0;
      crc_ctl.init = 1'b0;
      crc_ctl.feed = 1'b0;
    end
  end

  // running crc over device, command, sequence and payload
  fpp_crc16 u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (b),
    .crc  (crc_running)
  );

  // frame state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ST_H0;
      len_hi       <= '0;
      length_left  <= '0;
      frame_len    <= '0;
      payload_pos  <= '0;
      cmd_held     <= '0;
      crc_rx_hi    <= '0;
      crc_received <= '0;
    end else begin
      phase <= phase_next;
      if (rx_fire) begin
        case (phase)
          ST_LENH: len_hi <= b;
          ST_LENL: begin
            if (len_bad) begin
              length_left <= '0;
            end else begin
              length_left <= CNT_W'(plen16);
              frame_len   <= fpp_pkg::PLEN_W'(plen16);
              payload_pos <= '0;
            end
          end
          ST_CMD:  cmd_held <= b;
          ST_DATA: begin
            payload_pos <= payload_pos + 8'd1;
            length_left <= length_left - CNT_W'(1);
          end
          ST_CRCH: crc_rx_hi <= b;
          ST_CRCL: crc_received <= {crc_rx_hi, b};
          default: ;
        endcase
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_value    <= fpp_pkg::TAIL_VALUE_RST;
      payload_limit <= fpp_pkg::PAYLOAD_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        fpp_pkg::CFG_TAIL_VALUE:    tail_value    <= cfg.wdata[7:0];
        fpp_pkg::CFG_PAYLOAD_LIMIT: payload_limit <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.kind <= emit_kind;
      if (emit_kind == fpp_pkg::KIND_DATA) begin
        res.data_byte  <= b;
        res.byte_index <= payload_pos;
      end else begin
        res.data_byte  <= '0;
        res.byte_index <= '0;
      end
      if (emit_kind == fpp_pkg::KIND_LEN) begin
        res.command     <= '0;
        res.payload_len <= '0;
      end else begin
        res.command     <= cmd_held;
        res.payload_len <= frame_len;
      end
    end
  end

`ifndef SYNTHESIS
  // results only come from length check, payload or tail
  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    emit |-> (phase == ST_LENL || phase == ST_DATA || phase == ST_TAIL))
    else $error("result raised outside a result phase");

  // payload phase always has bytes left to take
  a_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == ST_DATA) |-> (length_left != '0))
    else $error("payload phase with no bytes left");

  // bytes left never exceed the frame payload length
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == ST_DATA) |-> (16'(length_left) <= 16'(frame_len)))
    else $error("payload count beyond frame length");

  // a tail byte always ends the frame with a result
  a_tail_end: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && phase == ST_TAIL) |=> (res.valid && phase == ST_H0))
    else $error("tail byte did not close the frame");

  // an empty result register never blocks the byte stream
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> rx.ready)
    else $error("input stalled with result register empty");
`endif

endmodule

`default_nettype wire

>>> rtl/fpp_crc16.sv
// fpp_crc16: running crc16-modbus register, one byte per cycle while feed is raised
// depends on fpp_pkg (crc16_feed, crc_ctl_t)
`default_nettype none

module fpp_crc16 (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fpp_pkg::crc_ctl_t ctl,
  input  wire logic [7:0]        data,
  output logic [15:0]            crc
);

  // restart on a new frame, otherwise fold in one byte when asked
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= fpp_pkg::CRC_INIT;
    end else if (ctl.init) begin
      crc <= fpp_pkg::CRC_INIT;
    end else if (ctl.feed) begin
      crc <= fpp_pkg::crc16_feed(crc, data);
    end
  end

endmodule

`default_nettype wire

>>> test/tb_framed_packet_parser_crc16_core.sv
`timescale 1ns / 1ps
// tb_framed_packet_parser_crc16_core: self-checking bench for the framed packet parser
// drives byte frames with random faults and config, checks results against a local parser model
// depends on fpp_pkg, fpp_if.sv and framed_packet_parser_crc16_core

module tb_framed_packet_parser_crc16_core;

  localparam int MAX_PAYLOAD    = 256;
  localparam int CLK_HALF       = 5;
  localparam int HOLD_CYCLES    = 4;
  localparam int DRAIN_LIMIT    = 100000;
  localparam int BYTES_PER_STEP = 200;

  // parser phases of the local model
  typedef enum logic [3:0] {
    ST_SYNC1, ST_SYNC2, ST_LEN_HI, ST_LEN_LO, ST_DEVICE, ST_COMMAND,
    ST_SEQUENCE, ST_PAYLOAD, ST_CRC_HI, ST_CRC_LO, ST_TAIL
  } frame_phase_t;

  // ways a generated frame can be damaged
  typedef enum {
    FR_GOOD, FR_BAD_CRC, FR_BAD_TAIL, FR_SHORT_LEN, FR_LONG_LEN, FR_BAD_SYNC, FR_CUT
  } frame_fault_t;

  typedef struct packed {
    logic [fpp_pkg::KIND_W-1:0] kind;
    logic [7:0]                 data_byte;
    logic [7:0]                 byte_index;
    logic [7:0]                 command;
    logic [fpp_pkg::PLEN_W-1:0] payload_len;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpp_byte_if   rx_if();
  fpp_result_if res_if();
  fpp_cfg_if    cfg_if();

  framed_packet_parser_crc16_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #(CLK_HALF) clk = ~clk;

  logic [7:0]    rx_bytes_pending[$];
  parse_result_t results_due[$];
  logic          rx_taken;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int            fail_count = 0;

  // config shadow
  logic [7:0]                 tail_cfg;
  logic [fpp_pkg::PLEN_W-1:0] limit_cfg;

  // model state
  frame_phase_t ps_phase;
  logic [15:0]  ps_len_left;
  logic [8:0]   ps_frame_len;
  logic [7:0]   ps_pos;
  logic [7:0]   ps_cmd;
  logic [15:0]  ps_crc;
  logic [15:0]  ps_crc_rcv;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // crc16-modbus, one input bit at a time, lsb first
  function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = (r >> 1) ^ ({16{fb}} & fpp_pkg::CRC_POLY);
    end
    return r;
  endfunction

  function automatic int eff_limit();
    return (limit_cfg < MAX_PAYLOAD) ? int'(limit_cfg) : MAX_PAYLOAD;
  endfunction

  // step the frame parser model by one accepted byte
  task automatic advance_frame_parser(input logic [7:0] b);
    parse_result_t r;
    int            flen;
    r = '0;
    case (ps_phase)
      ST_SYNC1: begin
        if (b == fpp_pkg::HDR_FIRST) ps_phase = ST_SYNC2;
      end
      ST_SYNC2: begin
        ps_phase = (b == fpp_pkg::HDR_SECOND) ? ST_LEN_HI : ST_SYNC1;
      end
      ST_LEN_HI: begin
        ps_len_left = {b, 8'h00};
        ps_phase    = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        flen = int'({ps_len_left[15:8], b});
        if (flen < int'(fpp_pkg::LEN_OVERHEAD) ||
            flen - int'(fpp_pkg::LEN_OVERHEAD) > eff_limit()) begin
          r.kind = fpp_pkg::KIND_LEN;
          results_due.push_back(r);
          ps_len_left = '0;
          ps_phase    = ST_SYNC1;
        end else begin
          ps_len_left  = 16'(flen - int'(fpp_pkg::LEN_OVERHEAD));
          ps_frame_len = 9'(flen - int'(fpp_pkg::LEN_OVERHEAD));
          ps_pos       = '0;
          ps_crc       = fpp_pkg::CRC_INIT;
          ps_phase     = ST_DEVICE;
        end
      end
      ST_DEVICE: begin
        ps_crc   = modbus_crc_next(ps_crc, b);
        ps_phase = ST_COMMAND;
      end
      ST_COMMAND: begin
        ps_crc   = modbus_crc_next(ps_crc, b);
        ps_cmd   = b;
        ps_phase = ST_SEQUENCE;
      end
      ST_SEQUENCE: begin
        ps_crc   = modbus_crc_next(ps_crc, b);
        ps_phase = (ps_len_left != 0) ? ST_PAYLOAD : ST_CRC_HI;
      end
      ST_PAYLOAD: begin
        ps_crc        = modbus_crc_next(ps_crc, b);
        r.kind        = fpp_pkg::KIND_DATA;
        r.data_byte   = b;
        r.byte_index  = ps_pos;
        r.command     = ps_cmd;
        r.payload_len = ps_frame_len;
        results_due.push_back(r);
        ps_pos = ps_pos + 8'd1;
        if (ps_len_left != 0) ps_len_left = ps_len_left - 16'd1;
        if (ps_len_left == 0) ps_phase = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        ps_crc_rcv = {b, 8'h00};
        ps_phase   = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        ps_crc_rcv = {ps_crc_rcv[15:8], b};
        ps_phase   = ST_TAIL;
      end
      ST_TAIL: begin
        // tail is judged before the crc
        if (b != tail_cfg) r.kind = fpp_pkg::KIND_TAIL;
        else if (ps_crc != ps_crc_rcv) r.kind = fpp_pkg::KIND_CRC;
        else r.kind = fpp_pkg::KIND_GOOD;
        r.command     = ps_cmd;
        r.payload_len = ps_frame_len;
        results_due.push_back(r);
        ps_phase = ST_SYNC1;
      end
      default: begin
        ps_phase = ST_SYNC1;
      end
    endcase
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result();
    parse_result_t got;
    parse_result_t want;
    got.kind        = res_if.kind;
    got.data_byte   = res_if.data_byte;
    got.byte_index  = res_if.byte_index;
    got.command     = res_if.command;
    got.payload_len = res_if.payload_len;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", got.kind));
    end else begin
      want = results_due.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.data_byte != want.data_byte)
        report_mismatch($sformatf("data_byte got %0h want %0h", got.data_byte, want.data_byte));
      if (got.byte_index != want.byte_index)
        report_mismatch($sformatf("byte_index got %0d want %0d",
                                  got.byte_index, want.byte_index));
      if (got.command != want.command)
        report_mismatch($sformatf("command got %0h want %0h", got.command, want.command));
      if (got.payload_len != want.payload_len)
        report_mismatch($sformatf("payload_len got %0d want %0d",
                                  got.payload_len, want.payload_len));
    end
  endtask

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      rx_taken     <= 1'b0;
      tail_cfg     = fpp_pkg::TAIL_VALUE_RST;
      limit_cfg    = fpp_pkg::PAYLOAD_LIMIT_RST;
      ps_phase     = ST_SYNC1;
      ps_len_left  = '0;
      ps_frame_len = '0;
      ps_pos       = '0;
      ps_cmd       = '0;
      ps_crc       = fpp_pkg::CRC_INIT;
      ps_crc_rcv   = '0;
      results_due.delete();
    end else begin
      rx_taken <= rx_if.valid && rx_if.ready;
      if (rx_if.valid && rx_if.ready) advance_frame_parser(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) check_result();
    end
  end

  // byte driver, fed from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_taken) begin
      if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_if.rx_byte <= rx_bytes_pending.pop_front();
        rx_if.valid   <= 1'b1;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    res_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // queue one frame, possibly damaged
  task automatic push_frame(input int plen, input frame_fault_t fault, input bit fixed_fill,
                            input logic [7:0] fill, output int pushed);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    logic [15:0] flen;
    logic [7:0]  v;
    int          lo_bound;
    int          keep;
    fb.push_back(fpp_pkg::HDR_FIRST);
    case (fault)
      FR_BAD_SYNC: begin
        do v = 8'($urandom_range(0, 255)); while (v == fpp_pkg::HDR_SECOND);
        fb.push_back(v);
      end
      FR_SHORT_LEN: begin
        fb.push_back(fpp_pkg::HDR_SECOND);
        fb.push_back(8'h00);
        fb.push_back(8'($urandom_range(0, 2)));
      end
      FR_LONG_LEN: begin
        lo_bound = eff_limit() + int'(fpp_pkg::LEN_OVERHEAD) + 1;
        case ($urandom_range(0, 9))
          0, 1, 2: flen = 16'(lo_bound);
          3:       flen = 16'hFFFF;
          default: flen = 16'($urandom_range(lo_bound, 65535));
        endcase
        fb.push_back(fpp_pkg::HDR_SECOND);
        fb.push_back(flen[15:8]);
        fb.push_back(flen[7:0]);
      end
      default: begin
        flen = 16'(plen) + fpp_pkg::LEN_OVERHEAD;
        fb.push_back(fpp_pkg::HDR_SECOND);
        fb.push_back(flen[15:8]);
        fb.push_back(flen[7:0]);
        crc = fpp_pkg::CRC_INIT;
        // device, command, sequence, then payload
        for (int i = 0; i < plen + 3; i++) begin
          v   = fixed_fill ? fill : 8'($urandom_range(0, 255));
          crc = modbus_crc_next(crc, v);
          fb.push_back(v);
        end
        if (fault == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        v = tail_cfg;
        if (fault == FR_BAD_TAIL) v = v ^ 8'($urandom_range(1, 255));
        fb.push_back(v);
      end
    endcase
    keep = fb.size();
    if (fault == FR_CUT) keep = $urandom_range(3, fb.size() - 1);
    for (int i = 0; i < keep; i++) rx_bytes_pending.push_back(fb[i]);
    pushed = keep;
  endtask

  // mostly well-formed frames with random content, some faults and line noise
  task automatic fill_random(input int target);
    int           count;
    int           n;
    int           r;
    int           eff;
    int           plen;
    frame_fault_t f;
    count = 0;
    eff   = eff_limit();
    if (eff == MAX_PAYLOAD) begin
      push_frame(eff, FR_GOOD, 1'b0, 8'h00, n);
      count += n;
    end
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) f = FR_GOOD;
        else if (r < 65) f = FR_BAD_CRC;
        else if (r < 75) f = FR_BAD_TAIL;
        else if (r < 83) f = FR_SHORT_LEN;
        else if (r < 90) f = FR_LONG_LEN;
        else if (r < 95) f = FR_BAD_SYNC;
        else f = FR_CUT;
        r = $urandom_range(0, 99);
        if (r < 3) plen = eff;
        else if (r < 8) plen = $urandom_range(0, eff);
        else plen = $urandom_range(0, (eff < 8) ? eff : 8);
        push_frame(plen, f, 1'b0, 8'h00, n);
        count += n;
      end
    end
  endtask

  // wait until every byte is taken and every result has come back, or the drain limit runs out
  task automatic settle_parser();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((rx_bytes_pending.size() != 0 || rx_if.valid || results_due.size() != 0)
               && waited < DRAIN_LIMIT);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [fpp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpp_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    cfg_if.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == fpp_pkg::CFG_TAIL_VALUE) tail_cfg = data[7:0];
    else if (idx == fpp_pkg::CFG_PAYLOAD_LIMIT) limit_cfg = data;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    int n;
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata     = '0;
    send_idle_pct    = 13;
    recv_idle_pct    = 64;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty good frame, wrong second sync byte, oversize length,
    // one-byte payload with bad crc
    push_frame(0, FR_GOOD, 1'b1, 8'h00, n);
    rx_bytes_pending.push_back(fpp_pkg::HDR_FIRST);
    rx_bytes_pending.push_back(fpp_pkg::HDR_FIRST);
    rx_bytes_pending.push_back(fpp_pkg::HDR_SECOND);
    rx_bytes_pending.push_back(fpp_pkg::HDR_FIRST);
    rx_bytes_pending.push_back(fpp_pkg::HDR_SECOND);
    rx_bytes_pending.push_back(8'hFF);
    rx_bytes_pending.push_back(8'hFF);
    push_frame(1, FR_BAD_CRC, 1'b1, 8'hFF, n);
    fill_random(BYTES_PER_STEP);
    settle_parser();

    // config sweeps, idle pattern changes along the way
    for (int step = 1; step <= 6; step++) begin
      if (step >= 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (step >= 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 13;
      end
      case (step)
        1: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, 9'h0FF);
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, 9'd256);
        end
        2: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, 9'h000);
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, 9'd0);
        end
        3: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, 9'($urandom_range(0, 255)));
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, 9'd5);
        end
        4: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, 9'($urandom_range(0, 255)));
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, 9'd1);
        end
        5: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, 9'($urandom_range(0, 255)));
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, 9'($urandom_range(0, 256)));
        end
        default: begin
          cfg_write(fpp_pkg::CFG_TAIL_VALUE, {1'b0, fpp_pkg::TAIL_VALUE_RST});
          cfg_write(fpp_pkg::CFG_PAYLOAD_LIMIT, fpp_pkg::PAYLOAD_LIMIT_RST);
        end
      endcase
      fill_random(BYTES_PER_STEP);
      settle_parser();
    end

    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
